/* design/affine_transform_matrix_builder_defines.svh */
// Assertion macros for the affine transform matrix builder checkers.
`ifndef AFFINE_TRANSFORM_MATRIX_BUILDER_DEFINES_SVH
`define AFFINE_TRANSFORM_MATRIX_BUILDER_DEFINES_SVH

// Implication into the next cycle, ignored while in reset
`define ATMB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Same-cycle implication, ignored while in reset
`define ATMB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset
`define ATMB_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* design/atmb_pkg.sv */
// ----------------------------------------------------------------------------
// atmb_pkg
// Types, constants and helper functions for the affine matrix builder.
// ----------------------------------------------------------------------------
`default_nettype none
package atmb_pkg;

  localparam int FULL_TURN    = 23040;
  localparam int HALF_TURN    = 11520;
  localparam int QUARTER_TURN = 5760;
  localparam int DEG_TO_RAD   = 292818;
  localparam int CORDIC_START = 652032874;
  localparam int ATAN_LEN     = 24;

  typedef struct packed {
    logic signed [15:0] angle_deg;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [47:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [47:0] m12;
  } out_item_t;

  // data handed from cell to cell: rotation state plus the item's other fields
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic               flip;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
  } cord_t;

  // arctangent of 2^-i, Q2.30
  function automatic logic signed [32:0] atan_q30(input logic [4:0] idx);
    logic signed [32:0] v;
    case (idx)
      5'd0:    v = 33'sd843314857;
      5'd1:    v = 33'sd497837829;
      5'd2:    v = 33'sd263043837;
      5'd3:    v = 33'sd133525159;
      5'd4:    v = 33'sd67021687;
      5'd5:    v = 33'sd33543516;
      5'd6:    v = 33'sd16775851;
      5'd7:    v = 33'sd8388437;
      5'd8:    v = 33'sd4194283;
      5'd9:    v = 33'sd2097149;
      5'd10:   v = 33'sd1048576;
      5'd11:   v = 33'sd524288;
      5'd12:   v = 33'sd262144;
      5'd13:   v = 33'sd131072;
      5'd14:   v = 33'sd65536;
      5'd15:   v = 33'sd32768;
      5'd16:   v = 33'sd16384;
      5'd17:   v = 33'sd8192;
      5'd18:   v = 33'sd4096;
      5'd19:   v = 33'sd2048;
      5'd20:   v = 33'sd1024;
      5'd21:   v = 33'sd512;
      5'd22:   v = 33'sd256;
      5'd23:   v = 33'sd128;
      default: v = 33'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7FFF_FFFF)
      r = 32'sh7FFF_FFFF;
    else if (v < -64'sh8000_0000)
      r = -32'sh8000_0000;
    else
      r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [47:0] r;
    if (v > 64'sh7FFF_FFFF_FFFF)
      r = 48'sh7FFF_FFFF_FFFF;
    else if (v < -64'sh8000_0000_0000)
      r = -48'sh8000_0000_0000;
    else
      r = v[47:0];
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/affine_transform_matrix_builder.sv */
// ----------------------------------------------------------------------------
// affine_transform_matrix_builder
// 2D affine matrix from angle, scale, origin and position, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_item  (angle, scale, origin, pos)
//  out     | output    | out_valid / out_ready| out_item (m00 .. m12)
//
// One item per cycle sustained while out_ready holds; the pipeline has two
// front stages, one cell per CORDIC step and four back stages.
// Synchronous reset clears every stage valid bit; payload is not reset.
// Each stage holds its item only while the one after it is full and stalled,
// so bubbles close up and input keeps flowing while a result waits.
`default_nettype none
module affine_transform_matrix_builder #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  atmb_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output atmb_pkg::out_item_t out_item
);
  import atmb_pkg::*;

  cord_t chain_d [0:CORDIC_STEPS];
  logic  chain_v [0:CORDIC_STEPS];
  logic  chain_r [0:CORDIC_STEPS];

  atmb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_item  (in_item),
    .dn_valid (chain_v[0]),
    .dn_ready (chain_r[0]),
    .dn_data  (chain_d[0])
  );

  // row of CORDIC cells
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    atmb_cell #(.STEP(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_v[i]),
      .up_ready (chain_r[i]),
      .up_data  (chain_d[i]),
      .dn_valid (chain_v[i+1]),
      .dn_ready (chain_r[i+1]),
      .dn_data  (chain_d[i+1])
    );
  end

  atmb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (chain_v[CORDIC_STEPS]),
    .up_ready (chain_r[CORDIC_STEPS]),
    .up_data  (chain_d[CORDIC_STEPS]),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_item  (out_item)
  );

endmodule
`default_nettype wire

/* design/atmb_front.sv */
// ----------------------------------------------------------------------------
// atmb_front
// Angle reduction and folding, then degree to radian conversion.
// ----------------------------------------------------------------------------
`default_nettype none
module atmb_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  atmb_pkg::in_item_t up_item,
  output logic              dn_valid,
  input  logic              dn_ready,
  output atmb_pkg::cord_t   dn_data
);
  import atmb_pkg::*;

  logic               v0_r, v1_r;
  logic               adv0, adv1;
  logic signed [13:0] n_r;
  logic               flip_r;
  in_item_t           it0_r;
  cord_t              c1_r;
  logic signed [16:0] a, n;
  logic               flip_nxt;
  logic signed [13:0] n_nxt;

  assign adv1     = !v1_r || dn_ready;
  assign adv0     = !v0_r || adv1;
  assign up_ready = adv0;
  assign dn_valid = v1_r;
  assign dn_data  = c1_r;

  // reduce beyond a full turn, negate, fold into +-90 degrees
  always_comb begin
    a = 17'(up_item.angle_deg);
    if (a > 17'(FULL_TURN))
      a = a - 17'(FULL_TURN);
    else if (a < -17'(FULL_TURN))
      a = a + 17'(FULL_TURN);
    n = -a;
    if (n > 17'(HALF_TURN))
      n = n - 17'(FULL_TURN);
    if (n < -17'(HALF_TURN))
      n = n + 17'(FULL_TURN);
    flip_nxt = 1'b0;
    if (n > 17'(QUARTER_TURN)) begin
      n = n - 17'(HALF_TURN);
      flip_nxt = 1'b1;
    end else if (n < -17'(QUARTER_TURN)) begin
      n = n + 17'(HALF_TURN);
      flip_nxt = 1'b1;
    end
    n_nxt = n[13:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      if (adv0) v0_r <= up_valid;
      if (adv1) v1_r <= v0_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (adv0 && up_valid) begin
      n_r    <= n_nxt;
      flip_r <= flip_nxt;
      it0_r  <= up_item;
    end
    if (adv1 && v0_r) begin
      c1_r.z        <= 33'(n_r * $signed(20'(DEG_TO_RAD)));
      c1_r.x        <= 34'(CORDIC_START);
      c1_r.y        <= '0;
      c1_r.flip     <= flip_r;
      c1_r.scale_x  <= it0_r.scale_x;
      c1_r.scale_y  <= it0_r.scale_y;
      c1_r.origin_x <= it0_r.origin_x;
      c1_r.origin_y <= it0_r.origin_y;
      c1_r.pos_x    <= it0_r.pos_x;
      c1_r.pos_y    <= it0_r.pos_y;
    end
  end

endmodule
`default_nettype wire

/* design/atmb_cell.sv */
// ----------------------------------------------------------------------------
// atmb_cell
// One CORDIC rotation step with its own stage register.
// ----------------------------------------------------------------------------
`default_nettype none
module atmb_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  atmb_pkg::cord_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output atmb_pkg::cord_t dn_data
);
  import atmb_pkg::*;

  logic               v_r, adv;
  cord_t              d_r, d_nxt;
  logic signed [33:0] dx, dy;
  logic signed [32:0] at;

  assign adv      = !v_r || dn_ready;
  assign up_ready = adv;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  // rotate toward zero residual angle
  always_comb begin
    dx    = up_data.y >>> STEP;
    dy    = up_data.x >>> STEP;
    at    = atan_q30(5'(STEP));
    d_nxt = up_data;
    if (!up_data.z[32]) begin
      d_nxt.x = up_data.x - dx;
      d_nxt.y = up_data.y + dy;
      d_nxt.z = up_data.z - at;
    end else begin
      d_nxt.x = up_data.x + dx;
      d_nxt.y = up_data.y - dy;
      d_nxt.z = up_data.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      v_r <= 1'b0;
    else if (adv)
      v_r <= up_valid;
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) d_r <= d_nxt;
  end

endmodule
`default_nettype wire

/* design/atmb_back.sv */
// ----------------------------------------------------------------------------
// atmb_back
// Scale products, rounding, origin products and translation sums.
// ----------------------------------------------------------------------------
`default_nettype none
module atmb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  atmb_pkg::cord_t     up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output atmb_pkg::out_item_t dn_item
);
  import atmb_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  logic signed [49:0] p00_r, p01_r, p10_r, p11_r;
  logic signed [23:0] ox1_r, oy1_r, px1_r, py1_r;
  logic signed [31:0] m00_r, m01_r, m10_r, m11_r;
  logic signed [23:0] ox2_r, oy2_r, px2_r, py2_r;
  logic signed [55:0] q00_r, q01_r, q10_r, q11_r;
  logic signed [23:0] px3_r, py3_r;
  logic signed [31:0] m00b_r, m01b_r, m10b_r, m11b_r;
  out_item_t          o_r;

  logic signed [33:0] xf, yf;
  logic signed [50:0] r00, r01, r10, r11;
  logic signed [57:0] t02, t12;

  assign adv4     = !v4_r || dn_ready;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign up_ready = adv1;
  assign dn_valid = v4_r;
  assign dn_item  = o_r;

  always_comb begin
    // half-turn fold negates sine and cosine
    xf  = up_data.flip ? -up_data.x : up_data.x;
    yf  = up_data.flip ? -up_data.y : up_data.y;
    // Q16.16 with round half up
    r00 = (51'(p00_r) + 51'sd2097152) >>> 22;
    r01 = (51'(p01_r) + 51'sd2097152) >>> 22;
    r10 = (-51'(p10_r) + 51'sd2097152) >>> 22;
    r11 = (51'(p11_r) + 51'sd2097152) >>> 22;
    // translation sums in Q24
    t02 = -58'(q00_r) - 58'(q01_r) + (58'(px3_r) <<< 16);
    t12 = -58'(q10_r) - 58'(q11_r) + (58'(py3_r) <<< 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= up_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    // scale times trig
    if (adv1 && up_valid) begin
      p00_r <= 50'(up_data.scale_x * xf);
      p01_r <= 50'(up_data.scale_y * yf);
      p10_r <= 50'(up_data.scale_x * yf);
      p11_r <= 50'(up_data.scale_y * xf);
      ox1_r <= up_data.origin_x;
      oy1_r <= up_data.origin_y;
      px1_r <= up_data.pos_x;
      py1_r <= up_data.pos_y;
    end
    // linear entries
    if (adv2 && v1_r) begin
      m00_r <= sat32(64'(r00));
      m01_r <= sat32(64'(r01));
      m10_r <= sat32(64'(r10));
      m11_r <= sat32(64'(r11));
      ox2_r <= ox1_r;
      oy2_r <= oy1_r;
      px2_r <= px1_r;
      py2_r <= py1_r;
    end
    // origin times entries
    if (adv3 && v2_r) begin
      q00_r  <= 56'(ox2_r * m00_r);
      q01_r  <= 56'(oy2_r * m01_r);
      q10_r  <= 56'(ox2_r * m10_r);
      q11_r  <= 56'(oy2_r * m11_r);
      px3_r  <= px2_r;
      py3_r  <= py2_r;
      m00b_r <= m00_r;
      m01b_r <= m01_r;
      m10b_r <= m10_r;
      m11b_r <= m11_r;
    end
    // output register
    if (adv4 && v3_r) begin
      o_r.m00 <= m00b_r;
      o_r.m01 <= m01b_r;
      o_r.m10 <= m10b_r;
      o_r.m11 <= m11b_r;
      o_r.m02 <= sat48(64'((t02 + 58'sd128) >>> 8));
      o_r.m12 <= sat48(64'((t12 + 58'sd128) >>> 8));
    end
  end

endmodule
`default_nettype wire

/* design/atmb_checker.sv */
// ----------------------------------------------------------------------------
// atmb_checker
// Port-level checks on the matrix builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "affine_transform_matrix_builder_defines.svh"
module atmb_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire                  out_valid,
  input wire                  out_ready,
  input atmb_pkg::out_item_t  out_item
);
  import atmb_pkg::*;

  // a waiting result stays put
  `ATMB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `ATMB_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_item), "stalled result changed")
  // reset empties the pipeline
  `ATMB_ASSERT_RST(a_rst_empty, !rst_n, !out_valid, "result shown after reset")
  // with the output free every stage can move, so input is taken
  `ATMB_ASSERT_NOW(a_ready_free, !out_valid, in_ready, "input blocked with empty output")

endmodule

bind affine_transform_matrix_builder atmb_checker u_atmb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire
